// ----- design/assert_macros.svh -----
// Assertion macros used by the oblagg_back design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a second condition in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Checks that a condition implies a second condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ----- design/oblagg_pkg.sv -----
package oblagg_pkg;

   localparam int ORDER_SLOTS_DEF  = 256;
   localparam int PRICE_LEVELS_DEF = 1024;
   localparam int TOTAL_W          = 40;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [1:0] MODE_NEW    = 2'd0;
   localparam logic [1:0] MODE_CHANGE = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic [1:0] ST_APPLIED   = 2'd0;
   localparam logic [1:0] ST_UNKNOWN   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] order_ref;
      logic        side;
      logic        price_ok;
      logic [31:0] level;
      logic [31:0] quantity;
   } cmd_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SUB_RD, S_SUB_WR, S_ADD_RD,
      S_ADD_WR, S_SLOT_WR, S_DONE
   } bstate_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               level_side;
      logic               removed_valid;
      logic signed [31:0] removed_price;
      logic [TOTAL_W-1:0] removed_total;
      logic               added_valid;
      logic signed [31:0] added_price;
      logic [TOTAL_W-1:0] added_total;
   } rsp_type;

endpackage

// ----- design/oblagg_req_if.sv -----
interface oblagg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [63:0]        order_ref;
   logic               side;
   logic signed [31:0] price;
   logic [31:0]        quantity;
   modport source (output valid, mode, order_ref, side, price, quantity, input ready);
   modport sink (input valid, mode, order_ref, side, price, quantity, output ready);
endinterface

// ----- design/oblagg_rsp_if.sv -----
interface oblagg_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               level_side;
   logic               removed_valid;
   logic signed [31:0] removed_price;
   logic [39:0]        removed_total;
   logic               added_valid;
   logic signed [31:0] added_price;
   logic [39:0]        added_total;
   modport source (output valid, status, level_side, removed_valid, removed_price,
      removed_total, added_valid, added_price, added_total, input ready);
   modport sink (input valid, status, level_side, removed_valid, removed_price,
      removed_total, added_valid, added_price, added_total, output ready);
endinterface

// ----- design/oblagg_front.sv -----
module oblagg_front #(
   parameter int PRICE_LEVELS = oblagg_pkg::PRICE_LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [31:0]    base_price,
   oblagg_req_if.sink            req,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output oblagg_pkg::cmd_type   cmd
);
   import oblagg_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_ptr_ff, wr_ptr_ff;
   logic signed [32:0] diff;
   logic              push, pop;
   cmd_type           new_cmd;

   always_comb begin
      diff = 33'(signed'(req.price)) - 33'(signed'(base_price));
      new_cmd.mode      = req.mode;
      new_cmd.order_ref = req.order_ref;
      new_cmd.side      = req.side;
      new_cmd.price_ok  = (diff >= 0) && (diff < 33'(PRICE_LEVELS));
      new_cmd.level     = diff[31:0];
      new_cmd.quantity  = req.quantity;
   end

   assign req.ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];
   assign cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= new_cmd;
   end

endmodule

// ----- design/oblagg_back.sv -----
`include "assert_macros.svh"
module oblagg_back #(
   parameter int ORDER_SLOTS  = oblagg_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_LEVELS = oblagg_pkg::PRICE_LEVELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [31:0]  base_price,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  oblagg_pkg::cmd_type cmd,
   oblagg_rsp_if.source        rsp
);
   import oblagg_pkg::*;

   localparam int SW = $clog2(ORDER_SLOTS);
   localparam int LW = $clog2(PRICE_LEVELS);
   localparam logic [TOTAL_W-1:0] TMAX = '1;

   logic [63:0]        id_mem   [ORDER_SLOTS];
   logic               side_mem [ORDER_SLOTS];
   logic [LW-1:0]      lvl_mem  [ORDER_SLOTS];
   logic [31:0]        qty_mem  [ORDER_SLOTS];
   logic [TOTAL_W-1:0] buy_mem  [PRICE_LEVELS];
   logic [TOTAL_W-1:0] sell_mem [PRICE_LEVELS];
   logic [ORDER_SLOTS-1:0] slot_valid_ff;

   bstate_type state_ff, state_in;
   cmd_type    cmd_ff;
   logic [SW:0]   idx_ff, idx_in;
   logic [LW-1:0] clr_ff;
   logic [SW-1:0] rd_idx_ff;
   logic          rd_ok_ff;
   logic [63:0]   rd_id_ff;
   logic          rd_side_ff;
   logic [LW-1:0] rd_lvl_ff;
   logic [31:0]   rd_qty_ff;
   logic          hit_ff;
   logic [SW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [SW-1:0] free_idx_ff;
   logic          o_side_ff;
   logic [LW-1:0] o_lvl_ff;
   logic [31:0]   o_qty_ff;
   logic          wside_ff;
   logic [LW-1:0] wlvl_ff;
   logic [TOTAL_W-1:0] tot_rd_ff;
   rsp_type       res_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;
   logic [SW-1:0] slot_sel;
   logic [TOTAL_W:0] sum;
   logic [TOTAL_W-1:0] tot_cur, tot_new;

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_CLEAR:     if (clr_ff == LW'(PRICE_LEVELS - 1)) state_in = S_IDLE;
         S_IDLE:      if (cmd_valid) begin state_in = S_SCAN; idx_in = '0; end
         S_SCAN:      begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (SW+1)'(ORDER_SLOTS - 1)) state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: state_in = S_DECIDE;
         S_DECIDE:    state_in = S_SUB_RD;
         S_SUB_RD:    state_in = S_SUB_WR;
         S_SUB_WR:    state_in = S_ADD_RD;
         S_ADD_RD:    state_in = S_ADD_WR;
         S_ADD_WR:    state_in = S_SLOT_WR;
         S_SLOT_WR:   state_in = S_DONE;
         S_DONE:      if (rsp_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   assign cmd_ready = (state_ff == S_IDLE);

   // Work flags derived from the scan result.
   logic do_sub, do_add, do_slot, do_free;
   logic [1:0] status_c;
   logic lside_c;
   always_comb begin
      do_sub = 1'b0; do_add = 1'b0; do_slot = 1'b0; do_free = 1'b0;
      status_c = ST_APPLIED; lside_c = 1'b0;
      slot_sel = hit_ff ? hit_idx_ff : free_idx_ff;
      case (cmd_ff.mode) inside
         MODE_NEW: begin
            lside_c = cmd_ff.side;
            if (!cmd_ff.price_ok) status_c = ST_RANGE;
            else if (!hit_ff && !free_ff) status_c = ST_FULL;
            else begin do_add = 1'b1; do_slot = 1'b1; end
         end
         MODE_CHANGE, MODE_CANCEL: begin
            slot_sel = hit_idx_ff;
            if (!hit_ff) status_c = ST_UNKNOWN;
            else begin
               lside_c = o_side_ff;
               if (cmd_ff.mode == MODE_CHANGE && !cmd_ff.price_ok) status_c = ST_RANGE;
               else begin
                  do_sub = 1'b1;
                  if (cmd_ff.mode == MODE_CHANGE) begin do_add = 1'b1; do_slot = 1'b1; end
                  else do_free = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      tot_cur = tot_rd_ff;
      sum     = {1'b0, tot_cur} + (TOTAL_W+1)'(cmd_ff.quantity);
      if (state_ff == S_SUB_WR)
         tot_new = (tot_cur > TOTAL_W'(o_qty_ff)) ? tot_cur - TOTAL_W'(o_qty_ff) : '0;
      else
         tot_new = sum[TOTAL_W] ? TMAX : sum[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         clr_ff        <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_ok_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         rd_ok_ff <= (state_ff == S_SCAN);
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_IDLE) begin hit_ff <= 1'b0; free_ff <= 1'b0; end
         if (rd_ok_ff) begin
            if (slot_valid_ff[rd_idx_ff] && rd_id_ff == cmd_ff.order_ref && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!slot_valid_ff[rd_idx_ff] && !free_ff) free_ff <= 1'b1;
         end
         if (state_ff == S_SLOT_WR) begin
            if (do_slot) slot_valid_ff[slot_sel] <= 1'b1;
            if (do_free) slot_valid_ff[slot_sel] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && cmd_valid) cmd_ff <= cmd;
      if (state_ff == S_CLEAR) begin
         buy_mem[clr_ff]  <= '0;
         sell_mem[clr_ff] <= '0;
      end
      rd_idx_ff  <= idx_ff[SW-1:0];
      rd_id_ff   <= id_mem[idx_ff[SW-1:0]];
      rd_side_ff <= side_mem[idx_ff[SW-1:0]];
      rd_lvl_ff  <= lvl_mem[idx_ff[SW-1:0]];
      rd_qty_ff  <= qty_mem[idx_ff[SW-1:0]];
      if (rd_ok_ff) begin
         if (slot_valid_ff[rd_idx_ff] && rd_id_ff == cmd_ff.order_ref && !hit_ff) begin
            hit_idx_ff <= rd_idx_ff;
            o_side_ff  <= rd_side_ff;
            o_lvl_ff   <= rd_lvl_ff;
            o_qty_ff   <= rd_qty_ff;
         end
         if (!slot_valid_ff[rd_idx_ff] && !free_ff) free_idx_ff <= rd_idx_ff;
      end
      if (state_ff == S_DECIDE) begin
         wside_ff <= o_side_ff;
         wlvl_ff  <= o_lvl_ff;
         res_ff <= '0;
      end
      if (state_ff == S_SUB_RD || state_ff == S_ADD_RD) begin
         tot_rd_ff <= wside_ff ? sell_mem[wlvl_ff] : buy_mem[wlvl_ff];
      end
      if (state_ff == S_SUB_WR) begin
         if (do_sub) begin
            if (wside_ff) sell_mem[wlvl_ff] <= tot_new;
            else buy_mem[wlvl_ff] <= tot_new;
            res_ff.removed_valid <= 1'b1;
            res_ff.removed_price <= base_price + 32'(wlvl_ff);
            res_ff.removed_total <= tot_new;
         end
         wside_ff <= (cmd_ff.mode == MODE_NEW) ? cmd_ff.side : o_side_ff;
         wlvl_ff  <= cmd_ff.level[LW-1:0];
      end
      if (state_ff == S_ADD_WR && do_add) begin
         if (wside_ff) sell_mem[wlvl_ff] <= tot_new;
         else buy_mem[wlvl_ff] <= tot_new;
         res_ff.added_valid <= 1'b1;
         res_ff.added_price <= base_price + 32'(wlvl_ff);
         res_ff.added_total <= tot_new;
      end
      if (state_ff == S_SLOT_WR) begin
         res_ff.status     <= status_c;
         res_ff.level_side <= lside_c;
         if (do_slot) begin
            id_mem[slot_sel]   <= cmd_ff.order_ref;
            side_mem[slot_sel] <= wside_ff;
            lvl_mem[slot_sel]  <= cmd_ff.level[LW-1:0];
            qty_mem[slot_sel]  <= cmd_ff.quantity;
         end
      end
      if (rsp_load) rsp_ff <= res_ff;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_ff.status;
   assign rsp.level_side    = rsp_ff.level_side;
   assign rsp.removed_valid = rsp_ff.removed_valid;
   assign rsp.removed_price = rsp_ff.removed_price;
   assign rsp.removed_total = rsp_ff.removed_total;
   assign rsp.added_valid   = rsp_ff.added_valid;
   assign rsp.added_price   = rsp_ff.added_price;
   assign rsp.added_total   = rsp_ff.added_total;

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, cmd_ready, state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_fail_quiet, clock, reset, rsp.valid && rsp.status != ST_APPLIED,
      !rsp.removed_valid && !rsp.added_valid)
   `ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == S_DONE && !rsp_valid_ff,
      rsp_valid_ff)
endmodule

// ----- design/order_book_level_aggregator.sv -----
// Order book price level aggregator.
// The req channel carries one order event per beat: mode (new, change,
// cancel), order reference, side, price and quantity. The rsp channel returns
// one beat per event with a status, the side touched, and the level totals
// that went down and up. The csr port writes base_price, which maps a price
// to level zero; write it only while the block is idle.
// Each event looks up its id by reading the order slot memory one entry per
// cycle, then updates the old and new level totals and the slot. The engine
// works on one event at a time and takes the next one from the queue only once
// it is back in idle.
// A two-entry queue decouples request acceptance from the lookup engine.
// Reset clears all slots and base_price at once; a clearing pass then zeroes
// the level totals, one price level after another. Request beats are queued
// from the cycle after reset falls. If the receiver holds rsp ready low, one
// response waits in the output register, the engine finishes one more event
// and holds it, and up to two further requests are queued before req ready
// drops.
module order_book_level_aggregator #(
   parameter int ORDER_SLOTS  = oblagg_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_LEVELS = oblagg_pkg::PRICE_LEVELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [31:0]        csr_wdata,
   oblagg_req_if.sink         req,
   oblagg_rsp_if.source       rsp
);
   import oblagg_pkg::*;

   logic signed [31:0] base_ff;
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) base_ff <= '0;
      else if (csr_write) base_ff <= csr_wdata;
   end

   oblagg_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
      .clock, .reset, .base_price(base_ff), .req,
      .cmd_valid, .cmd_ready, .cmd);

   oblagg_back #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_back (
      .clock, .reset, .base_price(base_ff),
      .cmd_valid, .cmd_ready, .cmd, .rsp);
endmodule

// ----- tb/tb_order_book_pkg.sv -----
package tb_order_book_pkg;
   import oblagg_pkg::*;

   localparam int SLOT_COUNT  = ORDER_SLOTS_DEF;
   localparam int LEVEL_COUNT = PRICE_LEVELS_DEF;
   localparam logic [39:0] TOTAL_CAP = 40'hFF_FFFF_FFFF;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   class book_scoreboard;
      bit          live[SLOT_COUNT];
      logic [63:0] ids[SLOT_COUNT];
      logic        sides[SLOT_COUNT];
      int          levels[SLOT_COUNT];
      logic [31:0] qtys[SLOT_COUNT];
      logic [39:0] buy_totals[LEVEL_COUNT];
      logic [39:0] sell_totals[LEVEL_COUNT];
      logic [31:0] base;
      rsp_type     pending[$];
      int          errors;

      function new();
         base = '0;
         errors = 0;
         foreach (live[i]) live[i] = 0;
         foreach (buy_totals[i]) begin
            buy_totals[i] = '0;
            sell_totals[i] = '0;
         end
      endfunction

      function int find_order(logic [63:0] id);
         for (int i = 0; i < SLOT_COUNT; i++)
            if (live[i] && ids[i] == id) return i;
         return -1;
      endfunction

      function int find_free();
         for (int i = 0; i < SLOT_COUNT; i++)
            if (!live[i]) return i;
         return -1;
      endfunction

      function bit level_of(logic signed [31:0] price, output int lvl);
         longint d;
         d = longint'(price) - longint'($signed(base));
         lvl = int'(d);
         return d >= 0 && d < LEVEL_COUNT;
      endfunction

      function logic [39:0] bump(logic sd, int lvl, logic [31:0] q, bit up);
         logic [40:0] s;
         logic [39:0] t;
         t = sd ? sell_totals[lvl] : buy_totals[lvl];
         if (up) begin
            s = t + q;
            t = s > TOTAL_CAP ? TOTAL_CAP : s[39:0];
         end else begin
            t = t > q ? t - q : '0;
         end
         if (sd) sell_totals[lvl] = t;
         else buy_totals[lvl] = t;
         return t;
      endfunction

      function void note_event(logic [1:0] mode, logic [63:0] id, logic sd,
                               logic signed [31:0] price, logic [31:0] q);
         rsp_type r;
         int lvl, s;
         bit ok;
         r = '0;
         ok = level_of(price, lvl);
         if (mode == MODE_NEW) begin
            r.level_side = sd;
            s = find_order(id);
            if (s < 0) s = find_free();
            if (!ok) r.status = ST_RANGE;
            else if (s < 0) r.status = ST_FULL;
            else begin
               live[s] = 1; ids[s] = id; sides[s] = sd; levels[s] = lvl; qtys[s] = q;
               r.added_valid = 1;
               r.added_price = base + lvl;
               r.added_total = bump(sd, lvl, q, 1);
            end
         end else if (mode == MODE_CHANGE || mode == MODE_CANCEL) begin
            s = find_order(id);
            if (s < 0) r.status = ST_UNKNOWN;
            else begin
               r.level_side = sides[s];
               if (mode == MODE_CHANGE && !ok) r.status = ST_RANGE;
               else begin
                  r.removed_valid = 1;
                  r.removed_price = base + levels[s];
                  r.removed_total = bump(sides[s], levels[s], qtys[s], 0);
                  if (mode == MODE_CHANGE) begin
                     levels[s] = lvl; qtys[s] = q;
                     r.added_valid = 1;
                     r.added_price = base + lvl;
                     r.added_total = bump(sides[s], lvl, q, 1);
                  end else begin
                     live[s] = 0;
                  end
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         if (got.level_side !== want.level_side)
            $display("%0t: level_side expected %0d actual %0d", $time,
                     want.level_side, got.level_side);
         if (got.removed_valid !== want.removed_valid)
            $display("%0t: removed_valid expected %0d actual %0d", $time,
                     want.removed_valid, got.removed_valid);
         if (got.removed_price !== want.removed_price)
            $display("%0t: removed_price expected %0d actual %0d", $time,
                     want.removed_price, got.removed_price);
         if (got.removed_total !== want.removed_total)
            $display("%0t: removed_total expected %0d actual %0d", $time,
                     want.removed_total, got.removed_total);
         if (got.added_valid !== want.added_valid)
            $display("%0t: added_valid expected %0d actual %0d", $time,
                     want.added_valid, got.added_valid);
         if (got.added_price !== want.added_price)
            $display("%0t: added_price expected %0d actual %0d", $time,
                     want.added_price, got.added_price);
         if (got.added_total !== want.added_total)
            $display("%0t: added_total expected %0d actual %0d", $time,
                     want.added_total, got.added_total);
         if (got !== want) errors++;
      endfunction
   endclass
endpackage

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import oblagg_pkg::*;
   import tb_order_book_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [31:0] csr_wdata = '0;
   longint      cycles = 0;
   bit          sender_busy = 1;
   bit          calm = 0;
   int          hold_off = 0;
   book_scoreboard book;
   logic [63:0] id_pool[16];

   oblagg_req_if req ();
   oblagg_rsp_if rsp ();

   order_book_level_aggregator uut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req.valid = 0; req.mode = '0; req.order_ref = '0; req.side = 0;
      req.price = '0; req.quantity = '0; rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3_000_000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type r;
      if (!reset && rsp.valid && rsp.ready) begin
         r.status = rsp.status; r.level_side = rsp.level_side;
         r.removed_valid = rsp.removed_valid; r.removed_price = rsp.removed_price;
         r.removed_total = rsp.removed_total; r.added_valid = rsp.added_valid;
         r.added_price = rsp.added_price; r.added_total = rsp.added_total;
         book.check_result(r);
      end
   end

   // The receiver stalls in bursts; hold_off forces one long stretch.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp.ready <= 0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
         end else begin
            rsp.ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_event(logic [1:0] mode, logic [63:0] id, logic sd,
                             logic signed [31:0] price, logic [31:0] q);
      int n;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req.valid <= 0;
         n = $urandom_range(1, 17);
         repeat (n) @(posedge clock);
      end
      req.valid <= 1; req.mode <= mode; req.order_ref <= id; req.side <= sd;
      req.price <= price; req.quantity <= q;
      do @(posedge clock); while (!req.ready);
      book.note_event(mode, id, sd, price, q);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_base(logic [31:0] b);
      drain();
      csr_write <= 1; csr_wdata <= b;
      @(posedge clock);
      csr_write <= 0;
      book.base = b;
   endtask

   function automatic logic signed [31:0] near_price();
      case ($urandom_range(0, 9))
         0: return book.base - $urandom_range(1, 3);
         1: return book.base + LEVEL_COUNT + $urandom_range(0, 2);
         2: return $urandom;
         3: return book.base + LEVEL_COUNT - 1;
         4: return book.base;
         default: return book.base + $urandom_range(0, 15);
      endcase
   endfunction

   function automatic logic [31:0] rand_qty();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return 0;
         2: return $urandom;
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   task automatic random_phase(int count, int id_span);
      logic [63:0] id;
      logic [1:0] mode;
      for (int i = 0; i < count; i++) begin
         id = $urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                                         : id_pool[$urandom_range(0, id_span - 1)];
         mode = $urandom_range(0, 9) == 0 ? MODE_SPARE : 2'($urandom_range(0, 2));
         send_event(mode, id, 1'($urandom), near_price(), rand_qty());
      end
   endtask

   initial begin
      book = new();
      foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_event(MODE_CANCEL, 64'd5, 0, 0, 0);
      send_event(MODE_CHANGE, 64'd5, 0, 0, 0);
      send_event(MODE_NEW, '0, 0, 32'sd0, 32'hFFFF_FFFF);
      send_event(MODE_NEW, '1, 1, 32'sd1023, 32'hFFFF_FFFF);
      send_event(MODE_NEW, 64'd7, 0, -32'sd1, 10);
      send_event(MODE_NEW, 64'd7, 1, 32'sd1024, 10);
      send_event(MODE_NEW, '0, 0, 32'sd0, 32'd5);
      send_event(MODE_CHANGE, '0, 1, 32'sd0, 32'd3);
      send_event(MODE_CHANGE, '1, 0, 32'sd2000, 32'd3);
      send_event(MODE_CHANGE, '1, 0, 32'sd500, 32'd9);
      send_event(MODE_SPARE, '1, 1, 32'sd1, 1);
      send_event(MODE_CANCEL, '1, 0, 0, 0);
      send_event(MODE_CANCEL, '0, 0, 0, 0);
      for (int i = 0; i < 6; i++)
         send_event(MODE_NEW, 64'd100, 1, 32'sd7, 32'hFFFF_FFFF);
      send_event(MODE_NEW, 64'd101, 1, 32'sd7, 32'hFFFF_FFFF);
      send_event(MODE_CANCEL, 64'd101, 0, 0, 0);

      // The receiver holds off while the sender keeps offering beats.
      hold_off = 1500;
      for (int i = 0; i < 6; i++)
         send_event(MODE_NEW, 64'd200 + i, i[0], 32'sd3, 32'd1);

      set_base(32'h7FFF_FE00);
      random_phase(150, 16);
      set_base(32'h8000_0000);
      random_phase(150, 16);
      set_base(32'hFFFF_FE00);
      random_phase(150, 16);

      // Fill the table, then hit it while full, then empty it.
      drain();
      set_base(32'd1000);
      for (int i = 0; i < SLOT_COUNT + 4; i++)
         send_event(MODE_NEW, 64'h1000 + i, 1'($urandom), 32'sd1000 + $urandom_range(0, 1023),
                    rand_qty());
      random_phase(60, 16);
      for (int i = 0; i < SLOT_COUNT + 4; i++)
         send_event(MODE_CANCEL, 64'h1000 + i, 0, 0, 0);

      set_base(32'hFFFF_FFF0);
      random_phase(200, 16);
      set_base($urandom);
      random_phase(120, 16);
      calm = 1;
      random_phase(120, 8);

      drain();
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
